### design/vtp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the vector transform / projection block.
// No dependencies.
package vtp_pkg;

  localparam int unsigned CompW   = 32;  // vector / matrix component, Q28.4
  localparam int unsigned FracW   = 4;   // fraction bits
  localparam int unsigned SumW    = CompW + FracW;  // bits of a row sum that matter
  localparam int unsigned DivSteps = SumW;          // one quotient bit per stage
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [SumW-1:0] RoundConst = SumW'(8);

  typedef enum logic [1:0] {
    CMD_XFORM   = 2'd0,
    CMD_INV_ROT = 2'd1,
    CMD_PROJECT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAIR_A = 3'd0,
    REG_PAIR_B = 3'd1,
    REG_PAIR_C = 3'd2,
    REG_PAIR_D = 3'd3,
    REG_LAST   = 3'd4
  } reg_idx_e;

  typedef logic signed [CompW-1:0] comp_t;

endpackage

### design/vector_transform_project.sv
`timescale 1ns / 1ps
// Top level of the vector transform / projection pipeline.
// Depends on vtp_pkg.
//
// Applies a configured 3x3 Q28.4 matrix to a Q28.4 vector: transform (M*v),
// inverse rotate (transpose(M)*v) or project (M*v, then x*16/z and y*16/z,
// truncated toward zero, z forced to 1 when zero, z answered as 0). One beat
// is accepted every cycle unless the master side stalls. The pipe has 41 register
// stages: input register, nine parallel 32x32 multipliers, three-term row sums
// with rounding, sign/magnitude prep, 36 restoring-division stages (one quotient
// bit each, x and y lanes side by side) and the output register. m_axis_tvalid
// rises when a beat reaches the output register. The whole pipe advances
// together whenever the output register is empty or being taken, so a stall
// on the master side holds every stage in place. The user must write the
// matrix registers through the cfg port only while idle; the block itself
// does not enforce this.
module vector_transform_project
  import vtp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [95:0]          s_axis_tdata,   // vec_x[31:0], vec_y[63:32], vec_z[95:64]
  input  logic [1:0]           s_axis_tuser,   // cmd[1:0]
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [95:0]          m_axis_tdata    // out_x[31:0], out_y[63:32], out_z[95:64]
);

  // ---------------------------------------------------------------- config
  logic [CfgW-1:0]  pair_a_q, pair_b_q, pair_c_q, pair_d_q;
  logic [CompW-1:0] last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_a_q <= CfgW'(16);
      pair_b_q <= '0;
      pair_c_q <= CfgW'(16);
      pair_d_q <= '0;
      last_q   <= CompW'(16);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PAIR_A: pair_a_q <= cfg_data_i;
        REG_PAIR_B: pair_b_q <= cfg_data_i;
        REG_PAIR_C: pair_c_q <= cfg_data_i;
        REG_PAIR_D: pair_d_q <= cfg_data_i;
        REG_LAST:   last_q   <= cfg_data_i[CompW-1:0];
        default: ;
      endcase
    end
  end

  comp_t mat [3][3];
  always_comb begin
    mat[0][0] = pair_a_q[31:0];
    mat[0][1] = pair_a_q[63:32];
    mat[0][2] = pair_b_q[31:0];
    mat[1][0] = pair_b_q[63:32];
    mat[1][1] = pair_c_q[31:0];
    mat[1][2] = pair_c_q[63:32];
    mat[2][0] = pair_d_q[31:0];
    mat[2][1] = pair_d_q[63:32];
    mat[2][2] = last_q;
  end

  // Whole pipe moves in lockstep.
  logic adv;
  logic out_vld_q;
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // ------------------------------------------------- stage 1: input register
  logic  s1_vld_q;
  cmd_e  s1_cmd_q;
  comp_t s1_coef_q [3][3];
  comp_t s1_vec_q  [3];
  comp_t coef_d    [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        // transpose selects column i instead of row i
        coef_d[i][j] = (cmd_e'(s_axis_tuser) == CMD_INV_ROT) ? mat[j][i] : mat[i][j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (adv) s1_vld_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q    <= cmd_e'(s_axis_tuser);
      s1_coef_q   <= coef_d;
      s1_vec_q[0] <= s_axis_tdata[31:0];
      s1_vec_q[1] <= s_axis_tdata[63:32];
      s1_vec_q[2] <= s_axis_tdata[95:64];
    end
  end

  // ------------------------------------------------------ stage 2: products
  // Only the low 36 bits of each product reach result bits 35:4.
  logic            s2_vld_q;
  cmd_e            s2_cmd_q;
  logic [SumW-1:0] s2_prod_q [3][3];
  logic [SumW-1:0] prod_d    [3][3];
  logic signed [2*CompW-1:0] full_prod;

  always_comb begin
    full_prod = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        full_prod    = s1_coef_q[i][j] * s1_vec_q[j];
        prod_d[i][j] = full_prod[SumW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (adv) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_cmd_q  <= s1_cmd_q;
      s2_prod_q <= prod_d;
    end
  end

  // ------------------------------------------- stage 3: row sums and round
  logic            s3_vld_q;
  cmd_e            s3_cmd_q;
  comp_t           s3_row_q [3];
  logic [SumW-1:0] acc_d    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = s2_prod_q[i][0] + s2_prod_q[i][1] + s2_prod_q[i][2] + RoundConst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (adv) s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_cmd_q <= s2_cmd_q;
      for (int i = 0; i < 3; i++) s3_row_q[i] <= acc_d[i][SumW-1:FracW];
    end
  end

  // -------------------------------- stage 4: sign / magnitude for division
  // Stage index 0 of the divider arrays holds the prepped operands.
  logic            dv_vld_q  [DivSteps+1];
  cmd_e            dv_cmd_q  [DivSteps+1];
  comp_t           dv_row_q  [DivSteps+1][3];
  logic [CompW-1:0] dv_den_q [DivSteps+1];
  logic            dv_negx_q [DivSteps+1];
  logic            dv_negy_q [DivSteps+1];
  logic [SumW-1:0] dv_nqx_q  [DivSteps+1];  // dividend bits shift out, quotient in
  logic [SumW-1:0] dv_nqy_q  [DivSteps+1];
  logic [CompW-1:0] dv_remx_q [DivSteps+1];
  logic [CompW-1:0] dv_remy_q [DivSteps+1];

  comp_t            z_eff;
  logic [SumW-1:0]  numx, numy;
  logic [CompW-1:0] den_mag;

  always_comb begin
    z_eff   = (s3_row_q[2] == '0) ? comp_t'(1) : s3_row_q[2];
    den_mag = z_eff[CompW-1] ? (~z_eff + 1'b1) : z_eff;
    numx    = {s3_row_q[0], {FracW{1'b0}}};
    numy    = {s3_row_q[1], {FracW{1'b0}}};
    if (s3_row_q[0][CompW-1]) numx = ~numx + 1'b1;
    if (s3_row_q[1][CompW-1]) numy = ~numy + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivSteps; k++) dv_vld_q[k] <= 1'b0;
    end else if (adv) begin
      dv_vld_q[0] <= s3_vld_q;
      for (int k = 1; k <= DivSteps; k++) dv_vld_q[k] <= dv_vld_q[k-1];
    end
  end

  // One restoring step per stage for each lane.
  logic [CompW:0]   tx [DivSteps], ty [DivSteps];
  logic             gex [DivSteps], gey [DivSteps];
  logic [CompW-1:0] remx_d [DivSteps], remy_d [DivSteps];

  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      tx[k]  = {dv_remx_q[k], dv_nqx_q[k][SumW-1]};
      ty[k]  = {dv_remy_q[k], dv_nqy_q[k][SumW-1]};
      gex[k] = tx[k] >= {1'b0, dv_den_q[k]};
      gey[k] = ty[k] >= {1'b0, dv_den_q[k]};
      remx_d[k] = gex[k] ? CompW'(tx[k] - {1'b0, dv_den_q[k]}) : tx[k][CompW-1:0];
      remy_d[k] = gey[k] ? CompW'(ty[k] - {1'b0, dv_den_q[k]}) : ty[k][CompW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_cmd_q[0]  <= s3_cmd_q;
      dv_row_q[0]  <= s3_row_q;
      dv_den_q[0]  <= den_mag;
      dv_negx_q[0] <= s3_row_q[0][CompW-1] ^ z_eff[CompW-1];
      dv_negy_q[0] <= s3_row_q[1][CompW-1] ^ z_eff[CompW-1];
      dv_nqx_q[0]  <= numx;
      dv_nqy_q[0]  <= numy;
      dv_remx_q[0] <= '0;
      dv_remy_q[0] <= '0;
      for (int k = 1; k <= DivSteps; k++) begin
        dv_cmd_q[k]  <= dv_cmd_q[k-1];
        dv_row_q[k]  <= dv_row_q[k-1];
        dv_den_q[k]  <= dv_den_q[k-1];
        dv_negx_q[k] <= dv_negx_q[k-1];
        dv_negy_q[k] <= dv_negy_q[k-1];
        dv_nqx_q[k]  <= {dv_nqx_q[k-1][SumW-2:0], gex[k-1]};
        dv_nqy_q[k]  <= {dv_nqy_q[k-1][SumW-2:0], gey[k-1]};
        dv_remx_q[k] <= remx_d[k-1];
        dv_remy_q[k] <= remy_d[k-1];
      end
    end
  end

  // ------------------------------------------------------- output register
  logic [CompW-1:0] qx, qy;
  comp_t            outx_d, outy_d, outz_d;
  logic [95:0]      out_data_q;

  always_comb begin
    qx = dv_nqx_q[DivSteps][CompW-1:0];
    qy = dv_nqy_q[DivSteps][CompW-1:0];
    if (dv_negx_q[DivSteps]) qx = ~qx + 1'b1;
    if (dv_negy_q[DivSteps]) qy = ~qy + 1'b1;
    case (dv_cmd_q[DivSteps])
      CMD_XFORM, CMD_INV_ROT: begin
        outx_d = dv_row_q[DivSteps][0];
        outy_d = dv_row_q[DivSteps][1];
        outz_d = dv_row_q[DivSteps][2];
      end
      CMD_PROJECT: begin
        outx_d = qx;
        outy_d = qy;
        outz_d = '0;
      end
      default: begin
        outx_d = '0;
        outy_d = '0;
        outz_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= dv_vld_q[DivSteps];
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_data_q <= {outz_d, outy_d, outx_d};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### test/vector_transform_project_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for vector_transform_project: directed table, then random
// vectors under several matrices, scored against a built-in fixed-point predictor.
// Depends on vtp_pkg and the RTL top level.
module vector_transform_project_tb
  import vtp_pkg::*;
;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vec3_t;

  typedef struct {
    cmd_e  cmd;
    vec3_t v;
    logic  has_exp;   // expected result typed into the table
    vec3_t exp_v;
  } stim_row_t;

  localparam int unsigned PipeDepth = 41;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // vec_x, vec_y, vec_z from bit 0 up
  logic [1:0] s_axis_tuser = '0;    // cmd
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;        // out_x, out_y, out_z from bit 0 up

  vector_transform_project u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor copy of the matrix, row-major.
  logic signed [31:0] mat [3][3];
  vec3_t results_due[$];
  int    n_errors = 0;
  int    n_beats_out = 0;
  int    n_cmd_seen [4] = '{0, 0, 0, 0};
  bit    quiet_tail = 1'b0;   // no idling on either side
  bit    sink_bursty = 1'b1;
  int    sink_idle = 0;       // stall cycles left in the current sink burst

  function automatic logic signed [31:0] row_sum(logic signed [31:0] a0, a1, a2, vec3_t v);
    logic [63:0] acc;
    acc = 64'(64'(signed'(a0)) * 64'(signed'(v.x)));
    acc += 64'(64'(signed'(a1)) * 64'(signed'(v.y)));
    acc += 64'(64'(signed'(a2)) * 64'(signed'(v.z)));
    acc += 64'd8;
    return acc[35:4];
  endfunction

  function automatic logic signed [31:0] depth_div(logic signed [31:0] num,
                                                   logic signed [31:0] den);
    longint q;
    q = (longint'(num) * 16) / longint'(den);  // truncates toward zero
    return q[31:0];
  endfunction

  function automatic vec3_t transform_vertex(cmd_e cmd, vec3_t v);
    vec3_t r;
    logic signed [31:0] dz;
    r = '0;
    case (cmd)
      CMD_XFORM, CMD_PROJECT: begin
        r.x = row_sum(mat[0][0], mat[0][1], mat[0][2], v);
        r.y = row_sum(mat[1][0], mat[1][1], mat[1][2], v);
        r.z = row_sum(mat[2][0], mat[2][1], mat[2][2], v);
        if (cmd == CMD_PROJECT) begin
          dz = (r.z == 0) ? 32'sd1 : r.z;   // zero depth divides by one
          r.x = depth_div(r.x, dz);
          r.y = depth_div(r.y, dz);
          r.z = '0;
        end
      end
      CMD_INV_ROT: begin
        r.x = row_sum(mat[0][0], mat[1][0], mat[2][0], v);
        r.y = row_sum(mat[0][1], mat[1][1], mat[2][1], v);
        r.z = row_sum(mat[0][2], mat[1][2], mat[2][2], v);
      end
      default: r = '0;   // unused command answers zeros
    endcase
    return r;
  endfunction

  // Drives one register write on the cfg port; mirrors the write into the predictor.
  task automatic write_reg(reg_idx_e idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_PAIR_A: begin mat[0][0] = data[31:0]; mat[0][1] = data[63:32]; end
      REG_PAIR_B: begin mat[0][2] = data[31:0]; mat[1][0] = data[63:32]; end
      REG_PAIR_C: begin mat[1][1] = data[31:0]; mat[1][2] = data[63:32]; end
      REG_PAIR_D: begin mat[2][0] = data[31:0]; mat[2][1] = data[63:32]; end
      default:    mat[2][2] = data[31:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_matrix(logic signed [31:0] m [9]);
    write_reg(REG_PAIR_A, {m[1], m[0]});
    write_reg(REG_PAIR_B, {m[3], m[2]});
    write_reg(REG_PAIR_C, {m[5], m[4]});
    write_reg(REG_PAIR_D, {m[7], m[6]});
    write_reg(REG_LAST, {32'h0, m[8]});
  endtask

  // Drops the source, waits until every result is in, then lets the pipe drain
  // before touching config.
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  // Pushes one beat; blocks until accepted and leaves tvalid high so the next
  // call can follow back to back. A random gap may precede it.
  task automatic send_vertex(cmd_e cmd, vec3_t v);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    results_due.push_back(transform_vertex(cmd, v));
    n_cmd_seen[cmd]++;
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom();                              // full range
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return $signed($urandom_range(0, 4000)) - 2000; // small, typical depth range
      default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  function automatic cmd_e rand_cmd();
    int k;
    k = $urandom_range(0, 15);
    if (k < 5) return CMD_XFORM;
    if (k < 10) return CMD_INV_ROT;
    if (k < 15) return CMD_PROJECT;
    return CMD_NONE;
  endfunction

  // Output side: random stall bursts, and scoring of each accepted beat.
  always @(posedge clk_i) begin
    vec3_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        n_beats_out++;
        if (results_due.size() == 0) begin
          $error("result beat with nothing expected: %h", m_axis_tdata);
          n_errors++;
        end else begin
          want = results_due.pop_front();
          if (got.x !== want.x) begin
            $error("out_x expected %0d actual %0d", want.x, got.x); n_errors++;
          end
          if (got.y !== want.y) begin
            $error("out_y expected %0d actual %0d", want.y, got.y); n_errors++;
          end
          if (got.z !== want.z) begin
            $error("out_z expected %0d actual %0d", want.z, got.z); n_errors++;
          end
        end
      end
      if (quiet_tail) begin
        m_axis_tready <= 1'b1;
        sink_idle     <= 0;
      end else if (sink_idle != 0) begin
        m_axis_tready <= 1'b0;
        sink_idle     <= sink_idle - 1;
      end else if (sink_bursty && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        sink_idle     <= $urandom_range(0, 13);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("vector_transform_project_tb: errors");
      $finish;
    end
  end

  stim_row_t directed [$];

  task automatic add_row(cmd_e c, logic signed [31:0] x, y, z,
                         logic he = 1'b0, vec3_t e = '0);
    stim_row_t r;
    r.cmd = c; r.v = '{z, y, x}; r.has_exp = he; r.exp_v = e;
    directed.push_back(r);
  endtask

  initial begin
    logic signed [31:0] m [9];
    vec3_t v;
    int phase;

    // Reset matrix is identity (1.0 = 16).
    foreach (mat[i, j]) mat[i][j] = (i == j) ? 32'sd16 : 32'sd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed table, identity matrix: results are readable by eye.
    add_row(CMD_XFORM, 32'sd16, -32'sd32, 32'sd48, 1'b1, '{32'sd48, -32'sd32, 32'sd16});
    add_row(CMD_INV_ROT, 32'sd5, 32'sd6, 32'sd7, 1'b1, '{32'sd7, 32'sd6, 32'sd5});
    add_row(CMD_NONE, 32'h7FFF_FFFF, 32'h8000_0000, -32'sd1, 1'b1, '0);
    // project: (32*16)/16 = 32, (-48*16)/16 = -48
    add_row(CMD_PROJECT, 32'sd32, -32'sd48, 32'sd16, 1'b1, '{32'sd0, -32'sd48, 32'sd32});
    // zero depth: divide by one, so x*16
    add_row(CMD_PROJECT, 32'sd3, -32'sd5, 32'sd0, 1'b1, '{32'sd0, -32'sd80, 32'sd48});
    add_row(CMD_XFORM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_row(CMD_XFORM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_row(CMD_PROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd1);
    add_row(CMD_PROJECT, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd1);
    add_row(CMD_INV_ROT, -32'sd1, -32'sd1, -32'sd1);
    add_row(CMD_PROJECT, 32'sd7, -32'sd7, 32'sd3);   // truncation toward zero
    add_row(CMD_XFORM, 32'sd0, 32'sd0, 32'sd0);

    foreach (directed[i]) begin
      send_vertex(directed[i].cmd, directed[i].v);
      if (directed[i].has_exp && results_due[$] !== directed[i].exp_v) begin
        $error("table row %0d: predictor disagrees with typed value", i);
        n_errors++;
      end
      results_due[$] = directed[i].has_exp ? directed[i].exp_v : results_due[$];
    end

    // Sender holds off until every result is back.
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);

    // Extreme matrices, incl. accumulator wrap with full-scale entries.
    drain_pipe();
    foreach (m[i]) m[i] = 32'h8000_0000;
    load_matrix(m);
    for (int i = 0; i < 8; i++) send_vertex(cmd_e'(i % 4), '{rand_comp(), rand_comp(), rand_comp()});
    drain_pipe();
    foreach (m[i]) m[i] = 32'h7FFF_FFFF;
    load_matrix(m);
    for (int i = 0; i < 8; i++) send_vertex(cmd_e'(i % 4), '{rand_comp(), rand_comp(), rand_comp()});

    // Random phases, each with a fresh matrix; the last runs without idling.
    for (phase = 0; phase < 6; phase++) begin
      drain_pipe();
      foreach (m[i]) m[i] = (phase % 2) ? rand_comp()
                                        : $signed($urandom_range(0, 64)) - 32;
      load_matrix(m);
      if (phase == 5) quiet_tail = 1'b1;
      sink_bursty = (phase != 2);
      for (int i = 0; i < 250; i++) begin
        v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp();
        send_vertex(rand_cmd(), v);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 8) @(posedge clk_i);

    $display("covered %0d transform, %0d inverse-rotate, %0d project, %0d unused-cmd beats",
             n_cmd_seen[0], n_cmd_seen[1], n_cmd_seen[2], n_cmd_seen[3]);
    $display("checked %0d result beats over 9 matrix settings", n_beats_out);
    if (n_errors == 0) begin
      $display("vector_transform_project_tb: clean");
    end else begin
      $display("vector_transform_project_tb: errors");
    end
    $finish;
  end

endmodule

### vector_transform_project.f
design/vtp_pkg.sv
design/vector_transform_project.sv
test/vector_transform_project_tb.sv
